// ===== rtl/core/owb_pkg.sv =====
// ----------------------------------------------------------------------------
// owb_pkg
// Types and codes shared by the 1-Wire bus master sequencer.
// ----------------------------------------------------------------------------
package owb_pkg;

   // item operation codes
   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_RESET = 2'd1;
   localparam logic [1:0] OP_WRITE = 2'd2;
   localparam logic [1:0] OP_READ  = 2'd3;

   // sequencer phases
   localparam logic [3:0] PH_IDLE     = 4'd0;
   localparam logic [3:0] PH_RLEAD    = 4'd1;
   localparam logic [3:0] PH_RLOW     = 4'd2;
   localparam logic [3:0] PH_RWAIT    = 4'd3;
   localparam logic [3:0] PH_RTAIL    = 4'd4;
   localparam logic [3:0] PH_WSTART   = 4'd5;
   localparam logic [3:0] PH_WSLOT    = 4'd6;
   localparam logic [3:0] PH_WTAIL    = 4'd7;
   localparam logic [3:0] PH_RDSTART  = 4'd8;
   localparam logic [3:0] PH_RDSAMPLE = 4'd9;
   localparam logic [3:0] PH_RDHOLD   = 4'd10;

   // register indexes
   localparam int unsigned CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_RESET_LEAD    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RESET_LOW     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PRESENCE_WAIT = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RESET_TAIL    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOT          = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOT_START    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_WRITE_TAIL    = 3'd6;

   localparam logic [3:0] BITS_PER_BYTE = 4'd8;

   typedef struct packed {
      logic [1:0] operation;
      logic [7:0] write_data;
      logic       line_level;
   } owb_req_type;

   typedef struct packed {
      logic       line_pull_low;
      logic       busy_res;
      logic       done_res;
      logic       device_present;
      logic [7:0] read_data;
      logic       command_dropped;
   } owb_rsp_type;

   typedef struct packed {
      logic [7:0] reset_lead_ticks;
      logic [7:0] reset_low_ticks;
      logic [7:0] presence_wait_ticks;
      logic [7:0] reset_tail_ticks;
      logic [7:0] slot_ticks;
      logic [3:0] slot_start_ticks;
      logic [7:0] write_tail_ticks;
   } owb_cfg_type;

   typedef struct packed {
      logic [3:0] phase;
      logic [7:0] tick_counter;
      logic [7:0] shift_byte;
      logic [3:0] bit_index;
      logic       presence_seen;
      logic       line_drive;
      logic [7:0] last_read;
   } owb_state_type;

endpackage

// ===== rtl/core/owb_csr.sv =====
// ----------------------------------------------------------------------------
// owb_csr
// Timing registers of the 1-Wire master, written through a plain write port.
// ----------------------------------------------------------------------------
module owb_csr import owb_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]           csr_wdata,
   output owb_cfg_type          cfg
);

   owb_cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.reset_lead_ticks    <= 8'd12;
         cfg_ff.reset_low_ticks     <= 8'd80;
         cfg_ff.presence_wait_ticks <= 8'd10;
         cfg_ff.reset_tail_ticks    <= 8'd5;
         cfg_ff.slot_ticks          <= 8'd5;
         cfg_ff.slot_start_ticks    <= 4'd1;
         cfg_ff.write_tail_ticks    <= 8'd5;
      end else if (csr_we) begin
         case (csr_index)
            CSR_RESET_LEAD:    cfg_ff.reset_lead_ticks    <= csr_wdata;
            CSR_RESET_LOW:     cfg_ff.reset_low_ticks     <= csr_wdata;
            CSR_PRESENCE_WAIT: cfg_ff.presence_wait_ticks <= csr_wdata;
            CSR_RESET_TAIL:    cfg_ff.reset_tail_ticks    <= csr_wdata;
            CSR_SLOT:          cfg_ff.slot_ticks          <= csr_wdata;
            CSR_SLOT_START:    cfg_ff.slot_start_ticks    <= csr_wdata[3:0];
            CSR_WRITE_TAIL:    cfg_ff.write_tail_ticks    <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/core/owb_step.sv =====
// ----------------------------------------------------------------------------
// owb_step
// Next-state and result logic for one item: phase countdown, phase exits,
// zero-length phase skipping, bit shifting and presence capture.
// ----------------------------------------------------------------------------
module owb_step import owb_pkg::*; (
   input  owb_cfg_type   cfg,
   input  owb_state_type cur,
   input  owb_req_type   req,
   output owb_state_type nxt,
   output owb_rsp_type   rsp
);

   logic [7:0] low1;
   logic [7:0] wait1;
   logic [7:0] slot1;
   logic [7:0] hold_len;
   logic [3:0] start1;
   logic [3:0] bit_inc;
   logic [7:0] rd_shift;
   logic       done;
   logic       dropped;

   assign low1     = (cfg.reset_low_ticks == 8'd0) ? 8'd1 : cfg.reset_low_ticks;
   assign wait1    = (cfg.presence_wait_ticks == 8'd0) ? 8'd1 : cfg.presence_wait_ticks;
   assign slot1    = (cfg.slot_ticks == 8'd0) ? 8'd1 : cfg.slot_ticks;
   assign start1   = (cfg.slot_start_ticks == 4'd0) ? 4'd1 : cfg.slot_start_ticks;
   assign hold_len = slot1 - 8'd1;
   assign bit_inc  = cur.bit_index + 4'd1;
   assign rd_shift = {req.line_level, cur.shift_byte[7:1]};

   always_comb begin
      nxt     = cur;
      done    = 1'b0;
      dropped = 1'b0;
      if (req.operation != OP_TICK) begin
         if (cur.phase != PH_IDLE) begin
            dropped = 1'b1;
         end else begin
            nxt.bit_index = 4'd0;
            case (req.operation)
               OP_RESET: begin
                  if (cfg.reset_lead_ticks != 8'd0) begin
                     nxt.phase        = PH_RLEAD;
                     nxt.tick_counter = cfg.reset_lead_ticks;
                     nxt.line_drive   = 1'b0;
                  end else begin
                     nxt.phase        = PH_RLOW;
                     nxt.tick_counter = low1;
                     nxt.line_drive   = 1'b1;
                  end
               end
               OP_WRITE: begin
                  nxt.shift_byte   = req.write_data;
                  nxt.phase        = PH_WSTART;
                  nxt.tick_counter = {4'd0, start1};
                  nxt.line_drive   = 1'b1;
               end
               default: begin
                  nxt.shift_byte   = 8'd0;
                  nxt.phase        = PH_RDSTART;
                  nxt.tick_counter = {4'd0, start1};
                  nxt.line_drive   = 1'b1;
               end
            endcase
         end
      end else if (cur.phase != PH_IDLE) begin
         if (cur.tick_counter > 8'd1) begin
            nxt.tick_counter = cur.tick_counter - 8'd1;
         end else begin
            case (cur.phase)
               PH_RLEAD: begin
                  nxt.phase        = PH_RLOW;
                  nxt.tick_counter = low1;
                  nxt.line_drive   = 1'b1;
               end
               PH_RLOW: begin
                  nxt.phase        = PH_RWAIT;
                  nxt.tick_counter = wait1;
                  nxt.line_drive   = 1'b0;
               end
               PH_RWAIT: begin
                  nxt.presence_seen = ~req.line_level;
                  if (cfg.reset_tail_ticks != 8'd0) begin
                     nxt.phase        = PH_RTAIL;
                     nxt.tick_counter = cfg.reset_tail_ticks;
                     nxt.line_drive   = 1'b0;
                  end else begin
                     nxt.phase = PH_IDLE;
                     done      = 1'b1;
                  end
               end
               PH_RTAIL, PH_WTAIL: begin
                  nxt.phase = PH_IDLE;
                  done      = 1'b1;
               end
               PH_WSTART: begin
                  nxt.phase        = PH_WSLOT;
                  nxt.tick_counter = slot1;
                  nxt.line_drive   = ~cur.shift_byte[0];
               end
               PH_WSLOT: begin
                  nxt.shift_byte = {1'b0, cur.shift_byte[7:1]};
                  nxt.bit_index  = bit_inc;
                  if (bit_inc >= BITS_PER_BYTE) begin
                     if (cfg.write_tail_ticks != 8'd0) begin
                        nxt.phase        = PH_WTAIL;
                        nxt.tick_counter = cfg.write_tail_ticks;
                        nxt.line_drive   = 1'b0;
                     end else begin
                        nxt.phase = PH_IDLE;
                        done      = 1'b1;
                     end
                  end else begin
                     nxt.phase        = PH_WSTART;
                     nxt.tick_counter = {4'd0, start1};
                     nxt.line_drive   = 1'b1;
                  end
               end
               PH_RDSTART: begin
                  nxt.phase        = PH_RDSAMPLE;
                  nxt.tick_counter = 8'd1;
                  nxt.line_drive   = 1'b0;
               end
               PH_RDSAMPLE, PH_RDHOLD: begin
                  if (cur.phase == PH_RDSAMPLE) begin
                     nxt.shift_byte = rd_shift;
                  end
                  if (cur.phase == PH_RDSAMPLE && hold_len != 8'd0) begin
                     nxt.phase        = PH_RDHOLD;
                     nxt.tick_counter = hold_len;
                     nxt.line_drive   = 1'b0;
                  end else begin
                     // end of hold, or of the sample when there is no hold: count the bit, finish on the eighth
                     nxt.bit_index = bit_inc;
                     if (bit_inc >= BITS_PER_BYTE) begin
                        nxt.last_read = nxt.shift_byte;
                        nxt.phase     = PH_IDLE;
                        done          = 1'b1;
                     end else begin
                        nxt.phase        = PH_RDSTART;
                        nxt.tick_counter = {4'd0, start1};
                        nxt.line_drive   = 1'b1;
                     end
                  end
               end
               default: begin
                  nxt.phase = PH_IDLE;
               end
            endcase
            if (nxt.phase == PH_IDLE) begin
               nxt.tick_counter = 8'd0;
               nxt.line_drive   = 1'b0;
            end
         end
      end
   end

   always_comb begin
      rsp.line_pull_low   = nxt.line_drive;
      rsp.busy_res        = (nxt.phase != PH_IDLE);
      rsp.done_res        = done;
      rsp.device_present  = nxt.presence_seen;
      rsp.read_data       = nxt.last_read;
      rsp.command_dropped = dropped;
   end

endmodule

// ===== rtl/core/onewire_bus_master.sv =====
// ----------------------------------------------------------------------------
// onewire_bus_master
// 1-Wire bus master sequencer: reset/presence, byte write and byte read
// commands, timed by tick items that carry the sampled line level.
//
//   channel  dir  handshake              payload
//   req      in   req_valid/req_ready    owb_req_type  (command or tick)
//   rsp      out  rsp_valid/rsp_ready    owb_rsp_type  (one per req item)
//   csr      in   csr_we                 csr_index, csr_wdata
//
// One item per cycle while req_ready is high; the sequencer state updates in the cycle of acceptance.
// Each item's result shows in the output register the cycle after acceptance.
// req_ready drops only while the output register holds an untaken result.
// Synchronous reset returns the sequencer to idle with default timing.
// ----------------------------------------------------------------------------
module onewire_bus_master import owb_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  owb_req_type          req_item,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output owb_rsp_type          rsp_item,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]           csr_wdata
);

   owb_cfg_type   cfg;
   owb_state_type state_ff;
   owb_state_type state_in;
   owb_rsp_type   rsp_ff;
   owb_rsp_type   rsp_in;
   logic          rsp_valid_ff;
   logic          accept;

   owb_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   owb_step u_step (
      .cfg (cfg),
      .cur (state_ff),
      .req (req_item),
      .nxt (state_in),
      .rsp (rsp_in)
   );

   assign req_ready = ~rsp_valid_ff | rsp_ready;
   assign accept    = req_valid & req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         state_ff     <= state_in;
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.done_res) |-> !rsp_ff.busy_res)
      else $error("done reported while still busy");

   a_idle_released: assert property (@(posedge clock) disable iff (reset)
      (state_ff.phase == PH_IDLE) |-> (!state_ff.line_drive && state_ff.tick_counter == 8'd0))
      else $error("idle sequencer drives the line or counts");

   a_drop_busy: assert property (@(posedge clock) disable iff (reset)
      (accept && state_ff.phase == PH_IDLE) |=> !rsp_ff.command_dropped)
      else $error("command dropped while idle");

   a_bit_range: assert property (@(posedge clock) disable iff (reset)
      state_ff.bit_index <= BITS_PER_BYTE)
      else $error("bit index past one byte");

endmodule
